[src/pidp_pkg.sv]
package pidp_pkg;

  // word and lane geometry
  localparam int WORD_BITS = 32;
  localparam int MIN_ELEM  = 2;
  localparam int NUM_LANES = WORD_BITS / MIN_ELEM;
  localparam int ELEM_MAX  = 16;
  localparam int SUM_W     = 32;
  localparam int CODE_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int EW_W      = 5;
  localparam int GROUP     = 4;
  localparam int NUM_GROUPS = NUM_LANES / GROUP;

  // width pair codes (A/B)
  localparam logic [CODE_W-1:0] WP_16_16 = 4'd0;
  localparam logic [CODE_W-1:0] WP_8_8   = 4'd1;
  localparam logic [CODE_W-1:0] WP_4_4   = 4'd2;
  localparam logic [CODE_W-1:0] WP_2_2   = 4'd3;
  localparam logic [CODE_W-1:0] WP_16_8  = 4'd4;
  localparam logic [CODE_W-1:0] WP_16_4  = 4'd5;
  localparam logic [CODE_W-1:0] WP_16_2  = 4'd6;
  localparam logic [CODE_W-1:0] WP_8_4   = 4'd7;
  localparam logic [CODE_W-1:0] WP_8_2   = 4'd8;
  localparam logic [CODE_W-1:0] WP_4_2   = 4'd9;
  localparam logic [CODE_W-1:0] WIDTH_PAIR_RESET = WP_8_8;

  // element widths
  localparam logic [EW_W-1:0] EW16 = 5'd16;
  localparam logic [EW_W-1:0] EW8  = 5'd8;
  localparam logic [EW_W-1:0] EW4  = 5'd4;
  localparam logic [EW_W-1:0] EW2  = 5'd2;
  localparam logic [EW_W-1:0] EW_NONE = 5'd0;

  // pairs that fit in one word for each A width
  localparam logic [COUNT_W:0] PAIRS16 = (COUNT_W+1)'(WORD_BITS / 16);
  localparam logic [COUNT_W:0] PAIRS8  = (COUNT_W+1)'(WORD_BITS / 8);
  localparam logic [COUNT_W:0] PAIRS4  = (COUNT_W+1)'(WORD_BITS / 4);
  localparam logic [COUNT_W:0] PAIRS2  = (COUNT_W+1)'(WORD_BITS / 2);

  // pipeline stage control
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  function automatic logic [EW_W-1:0] a_width_of(input logic [CODE_W-1:0] code);
    logic [EW_W-1:0] w;
    unique case (code)
      WP_16_16, WP_16_8, WP_16_4, WP_16_2: w = EW16;
      WP_8_8, WP_8_4, WP_8_2:              w = EW8;
      WP_4_4, WP_4_2:                      w = EW4;
      WP_2_2:                              w = EW2;
      default:                             w = EW_NONE;
    endcase
    return w;
  endfunction

  function automatic logic [EW_W-1:0] b_width_of(input logic [CODE_W-1:0] code);
    logic [EW_W-1:0] w;
    unique case (code)
      WP_16_16:                            w = EW16;
      WP_8_8, WP_16_8:                     w = EW8;
      WP_4_4, WP_16_4, WP_8_4:             w = EW4;
      WP_2_2, WP_16_2, WP_8_2, WP_4_2:     w = EW2;
      default:                             w = EW_NONE;
    endcase
    return w;
  endfunction

  // clamp limit on the pair count; unused codes use no pairs
  function automatic logic [COUNT_W:0] max_pairs(input logic [CODE_W-1:0] code);
    logic [COUNT_W:0] n;
    unique case (a_width_of(code))
      EW16:    n = PAIRS16;
      EW8:     n = PAIRS8;
      EW4:     n = PAIRS4;
      EW2:     n = PAIRS2;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

[src/packed_int_dot_product.sv]
// packed integer dot product, sixteen multiplier lanes and a registered adder tree
// a last transaction's sum passes the product, group-sum and total registers, then is registered on dot_sum
// throughput: one transaction per cycle while in_stall is low, set by the accumulator add
// non-last transactions keep flowing while a result waits on a stalled output
// reset (rst, synchronous): pipeline emptied, accumulator zero, width_pair 8/8
module packed_int_dot_product (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [pidp_pkg::CODE_W-1:0]         cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pidp_pkg::WORD_BITS-1:0]      a_word,
  input  logic [pidp_pkg::WORD_BITS-1:0]      b_bits,
  input  logic [pidp_pkg::COUNT_W-1:0]        element_count,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pidp_pkg::SUM_W-1:0]   dot_sum
);

  logic [pidp_pkg::CODE_W-1:0] width_pair;
  pidp_pkg::stage_ctl_t lane_ctl;
  logic [pidp_pkg::NUM_LANES-1:0][pidp_pkg::SUM_W-1:0] products;
  logic take, lane_load;

  // width pair register
  always_ff @(posedge clk) begin
    if (rst) begin
      width_pair <= pidp_pkg::WIDTH_PAIR_RESET;
    end else if (cfg_wr_en) begin
      width_pair <= cfg_wr_data;
    end
  end

  // lane stage control
  assign lane_load = !lane_ctl.valid || take;
  assign in_stall  = !lane_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_ctl <= '0;
    end else if (lane_load) begin
      lane_ctl.valid <= in_valid;
      lane_ctl.last  <= last;
    end
  end

  // multiplier lanes
  for (genvar i = 0; i < pidp_pkg::NUM_LANES; i++) begin : g_lane
    logic signed [pidp_pkg::SUM_W-1:0] product;

    pidp_lane #(
      .LANE(i)
    ) u_lane (
      .clk           (clk),
      .en            (lane_load),
      .a_word        (a_word),
      .b_bits        (b_bits),
      .element_count (element_count),
      .width_pair    (width_pair),
      .product       (product)
    );

    assign products[i] = product;
  end

  // adder tree, accumulator and output
  pidp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lane_ctl  (lane_ctl),
    .products  (products),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dot_sum   (dot_sum)
  );

endmodule

[src/pidp_lane.sv]
module pidp_lane #(
  parameter int LANE = 0
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [pidp_pkg::WORD_BITS-1:0]      a_word,
  input  logic [pidp_pkg::WORD_BITS-1:0]      b_bits,
  input  logic [pidp_pkg::COUNT_W-1:0]        element_count,
  input  logic [pidp_pkg::CODE_W-1:0]         width_pair,
  output logic signed [pidp_pkg::SUM_W-1:0]   product
);

  localparam int SH16 = LANE * 16;
  localparam int SH8  = LANE * 8;
  localparam int SH4  = LANE * 4;
  localparam int SH2  = LANE * 2;
  localparam logic [pidp_pkg::COUNT_W:0] LANE_IDX = (pidp_pkg::COUNT_W+1)'(LANE);

  logic [pidp_pkg::WORD_BITS-1:0] a_sh16, a_sh8, a_sh4, a_sh2;
  logic [pidp_pkg::WORD_BITS-1:0] b_sh16, b_sh8, b_sh4, b_sh2;
  logic signed [pidp_pkg::ELEM_MAX-1:0] a_op, b_op;
  logic signed [pidp_pkg::SUM_W-1:0]    prod_full;
  logic signed [pidp_pkg::SUM_W-1:0]    product_next;
  logic lane_used;

  // bring this lane's element down to bit 0; lanes above the word read zero
  assign a_sh16 = a_word >> SH16;
  assign a_sh8  = a_word >> SH8;
  assign a_sh4  = a_word >> SH4;
  assign a_sh2  = a_word >> SH2;
  assign b_sh16 = b_bits >> SH16;
  assign b_sh8  = b_bits >> SH8;
  assign b_sh4  = b_bits >> SH4;
  assign b_sh2  = b_bits >> SH2;

  // sign-extended A operand
  always_comb begin
    unique case (pidp_pkg::a_width_of(width_pair))
      pidp_pkg::EW16: a_op = a_sh16[15:0];
      pidp_pkg::EW8:  a_op = {{8{a_sh8[7]}}, a_sh8[7:0]};
      pidp_pkg::EW4:  a_op = {{12{a_sh4[3]}}, a_sh4[3:0]};
      pidp_pkg::EW2:  a_op = {{14{a_sh2[1]}}, a_sh2[1:0]};
      default:        a_op = '0;
    endcase
  end

  // sign-extended B operand
  always_comb begin
    unique case (pidp_pkg::b_width_of(width_pair))
      pidp_pkg::EW16: b_op = b_sh16[15:0];
      pidp_pkg::EW8:  b_op = {{8{b_sh8[7]}}, b_sh8[7:0]};
      pidp_pkg::EW4:  b_op = {{12{b_sh4[3]}}, b_sh4[3:0]};
      pidp_pkg::EW2:  b_op = {{14{b_sh2[1]}}, b_sh2[1:0]};
      default:        b_op = '0;
    endcase
  end

  // lane takes part only below the clamped count
  assign lane_used = (LANE_IDX < {1'b0, element_count}) &&
                     (LANE_IDX < pidp_pkg::max_pairs(width_pair));

  // signed product at full sum width
  assign prod_full    = a_op * b_op;
  assign product_next = lane_used ? prod_full : '0;

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      product <= product_next;
    end
  end

endmodule

[src/pidp_merge.sv]
module pidp_merge (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  pidp_pkg::stage_ctl_t                                 lane_ctl,
  input  logic [pidp_pkg::NUM_LANES-1:0][pidp_pkg::SUM_W-1:0]  products,
  output logic                                                 take,
  output logic                                                 out_valid,
  input  logic                                                 out_stall,
  output logic signed [pidp_pkg::SUM_W-1:0]                    dot_sum
);

  pidp_pkg::stage_ctl_t grp_ctl, tot_ctl;
  logic [pidp_pkg::NUM_GROUPS-1:0][pidp_pkg::SUM_W-1:0] grp_sum, grp_sum_next;
  logic [pidp_pkg::SUM_W-1:0] total, total_next;
  logic [pidp_pkg::SUM_W-1:0] accumulator, acc_sum;
  logic out_free, tot_load, tot_consume, grp_load;

  // stage handshakes: a non-last total stage never waits on the output
  assign out_free    = !out_valid || !out_stall;
  assign tot_consume = tot_ctl.valid && (!tot_ctl.last || out_free);
  assign tot_load    = !tot_ctl.valid || tot_consume;
  assign grp_load    = !grp_ctl.valid || tot_load;
  assign take        = grp_load;

  // first level of the tree: groups of four lanes
  always_comb begin
    for (int g = 0; g < pidp_pkg::NUM_GROUPS; g++) begin
      grp_sum_next[g] = '0;
      for (int k = 0; k < pidp_pkg::GROUP; k++) begin
        grp_sum_next[g] = grp_sum_next[g] + products[g*pidp_pkg::GROUP + k];
      end
    end
  end

  // second level of the tree
  always_comb begin
    total_next = '0;
    for (int g = 0; g < pidp_pkg::NUM_GROUPS; g++) begin
      total_next = total_next + grp_sum[g];
    end
  end

  assign acc_sum = accumulator + total;

  // tree registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_ctl <= '0;
      tot_ctl <= '0;
    end else begin
      if (grp_load) begin
        grp_ctl <= lane_ctl;
      end
      if (tot_load) begin
        tot_ctl <= grp_ctl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_sum <= grp_sum_next;
    end
    if (tot_load) begin
      total <= total_next;
    end
  end

  // accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (tot_consume) begin
        if (tot_ctl.last) begin
          accumulator <= '0;
          out_valid   <= 1'b1;
        end else begin
          accumulator <= acc_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tot_consume && tot_ctl.last) begin
      dot_sum <= acc_sum;
    end
  end

  // a last transaction leaving the tree raises the output
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (tot_consume && tot_ctl.last) |=> out_valid)
    else $error("last transaction did not produce a result");

  // the accumulator starts from zero after a result
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (tot_consume && tot_ctl.last) |=> (accumulator == '0))
    else $error("accumulator not cleared after last");

  // a blocked last transaction holds its stage
  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    (tot_ctl.valid && tot_ctl.last && !out_free) |=>
      (tot_ctl.valid && tot_ctl.last && $stable(total)))
    else $error("blocked last transaction lost");

endmodule

[dv/tb_packed_int_dot_product.sv]
`timescale 1ns / 1ps

module tb_packed_int_dot_product;

  // width codes the block leaves unused
  localparam logic [pidp_pkg::CODE_W-1:0] WP_SPARE_LO  = 4'd10;
  localparam logic [pidp_pkg::CODE_W-1:0] WP_SPARE_MID = 4'd13;
  localparam logic [pidp_pkg::CODE_W-1:0] WP_SPARE_HI  = 4'd15;

  // edge patterns: all ones, zero, most negative and most positive lanes per width
  localparam logic [pidp_pkg::WORD_BITS-1:0] EDGE_WORDS [10] = '{
    32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_8000, 32'h8080_8080, 32'h8888_8888,
    32'hAAAA_AAAA, 32'h7FFF_7FFF, 32'h7F7F_7F7F, 32'h7777_7777, 32'h5555_5555
  };

  // running dot-product predictor and store of expected sums
  class dot_sum_scoreboard;
    logic [pidp_pkg::CODE_W-1:0] width_code;
    logic [pidp_pkg::SUM_W-1:0]  running_sum;
    logic [pidp_pkg::SUM_W-1:0]  sums_q[$];
    int errors;
    int n_items;
    int n_sums;

    function new();
      width_code  = pidp_pkg::WP_8_8;
      running_sum = '0;
      errors      = 0;
      n_items     = 0;
      n_sums      = 0;
    endfunction

    function void set_code(logic [pidp_pkg::CODE_W-1:0] code);
      width_code = code;
    endfunction

    function int pending();
      return sums_q.size();
    endfunction

    // signed lane of the given width starting at bit pos
    function int lane_value(logic [pidp_pkg::WORD_BITS-1:0] w, int pos, int width);
      int raw;
      int sgn;
      raw = int'((w >> pos) & ((32'd1 << width) - 32'd1));
      sgn = 1 << (width - 1);
      return (raw ^ sgn) - sgn;
    endfunction

    // accumulate one accepted input transaction
    function void note_item(logic [pidp_pkg::WORD_BITS-1:0] a,
                            logic [pidp_pkg::WORD_BITS-1:0] b,
                            logic [pidp_pkg::COUNT_W-1:0] count, logic lst);
      int wa;
      int wb;
      int pairs;
      int ea;
      int eb;
      unique case (width_code)
        pidp_pkg::WP_16_16: begin wa = 16; wb = 16; end
        pidp_pkg::WP_8_8:   begin wa = 8;  wb = 8;  end
        pidp_pkg::WP_4_4:   begin wa = 4;  wb = 4;  end
        pidp_pkg::WP_2_2:   begin wa = 2;  wb = 2;  end
        pidp_pkg::WP_16_8:  begin wa = 16; wb = 8;  end
        pidp_pkg::WP_16_4:  begin wa = 16; wb = 4;  end
        pidp_pkg::WP_16_2:  begin wa = 16; wb = 2;  end
        pidp_pkg::WP_8_4:   begin wa = 8;  wb = 4;  end
        pidp_pkg::WP_8_2:   begin wa = 8;  wb = 2;  end
        pidp_pkg::WP_4_2:   begin wa = 4;  wb = 2;  end
        default:            begin wa = 0;  wb = 0;  end
      endcase
      n_items++;
      // spare codes use no pairs; otherwise clamp to what fits in a word
      if (wa == 0) pairs = 0;
      else if (int'(count) > pidp_pkg::WORD_BITS / wa) pairs = pidp_pkg::WORD_BITS / wa;
      else pairs = int'(count);
      for (int i = 0; i < pairs; i++) begin
        ea = lane_value(a, i * wa, wa);
        eb = lane_value(b, i * wb, wb);
        running_sum += pidp_pkg::SUM_W'(ea * eb);
      end
      if (lst) begin
        sums_q.push_back(running_sum);
        running_sum = '0;
      end
    endfunction

    // compare one accepted output transaction with the oldest expected sum
    function void check_sum(logic [pidp_pkg::SUM_W-1:0] got);
      logic [pidp_pkg::SUM_W-1:0] want;
      n_sums++;
      if (sums_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected dot_sum, expected none, actual %0d", $time, $signed(got));
      end else begin
        want = sums_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: dot_sum mismatch, expected %0d, actual %0d",
                   $time, $signed(want), $signed(got));
        end
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              cfg_wr_en;
  logic [pidp_pkg::CODE_W-1:0]       cfg_wr_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [pidp_pkg::WORD_BITS-1:0]    a_word;
  logic [pidp_pkg::WORD_BITS-1:0]    b_bits;
  logic [pidp_pkg::COUNT_W-1:0]      element_count;
  logic                              last;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [pidp_pkg::SUM_W-1:0] dot_sum;

  dot_sum_scoreboard sb;
  bit sender_burst;
  int long_hold_req;
  int n_writes;

  packed_int_dot_product u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .a_word        (a_word),
    .b_bits        (b_bits),
    .element_count (element_count),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .dot_sum       (dot_sum)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watch both channels for completed transactions
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_item(a_word, b_bits, element_count, last);
    if (!rst && out_valid && !out_stall) sb.check_sum(dot_sum);
  end

  // write the width register while the block is idle
  task automatic write_width(input logic [pidp_pkg::CODE_W-1:0] code);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_code(code);
    n_writes++;
  endtask

  // offer one input transaction after a random gap, return at its acceptance edge
  task automatic send_item(input logic [pidp_pkg::WORD_BITS-1:0] a,
                           input logic [pidp_pkg::WORD_BITS-1:0] b,
                           input logic [pidp_pkg::COUNT_W-1:0] count, input logic lst);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    a_word        <= a;
    b_bits        <= b;
    element_count <= count;
    last          <= lst;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering, wait for every expected sum, then let the pipeline settle
  task automatic end_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [pidp_pkg::WORD_BITS-1:0] pick_word();
    return ($urandom_range(0, 7) == 0) ? EDGE_WORDS[$urandom_range(0, 9)] : $urandom;
  endfunction

  // random vectors of one to six words, with some stray last flags
  task automatic run_vectors(input int n_words);
    int sent;
    int len;
    logic [pidp_pkg::COUNT_W-1:0] count;
    logic lst;
    sent = 0;
    while (sent < n_words) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0:       count = pidp_pkg::COUNT_W'($urandom_range(0, 31));
          1:       count = pidp_pkg::COUNT_W'($urandom_range(1, 16));
          default: count = pidp_pkg::COUNT_W'(16);
        endcase
        lst = (i == len - 1);
        if ($urandom_range(0, 9) == 0) lst = 1'($urandom_range(0, 1));
        send_item(pick_word(), pick_word(), count, lst);
        sent++;
      end
    end
  endtask

  // output side: random holds, quiet stretches and one long hold on request
  initial begin
    int hold;
    int quiet;
    out_stall <= 1'b0;
    quiet = 0;
    forever begin
      if (long_hold_req > 0) begin
        hold = long_hold_req;
        long_hold_req = 0;
      end else if (quiet > 0) begin
        hold = 0;
        quiet--;
      end else begin
        if ($urandom_range(0, 5) == 0) quiet = 20;
        hold = $urandom_range(0, 8);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("** packed_int_dot_product: FAILED **");
    $finish;
  end

  // main sequence
  initial begin
    logic [pidp_pkg::CODE_W-1:0] phase_codes [15];
    phase_codes = '{pidp_pkg::WP_16_16, pidp_pkg::WP_8_8, pidp_pkg::WP_4_4,
                    pidp_pkg::WP_2_2, pidp_pkg::WP_16_8, pidp_pkg::WP_16_4,
                    pidp_pkg::WP_16_2, pidp_pkg::WP_8_4, pidp_pkg::WP_8_2,
                    pidp_pkg::WP_4_2, WP_SPARE_LO, WP_SPARE_MID, WP_SPARE_HI,
                    pidp_pkg::WP_2_2, pidp_pkg::WP_16_16};
    sb = new();
    n_writes      = 0;
    long_hold_req = 0;
    sender_burst  = 1'b0;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    a_word        <= '0;
    b_bits        <= '0;
    element_count <= '0;
    last          <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset width 8/8, sign extremes, clamped and zero counts
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd4, 1'b1);
    send_item(32'h8080_8080, 32'h8080_8080, 5'd4, 1'b0);
    send_item(32'h7F7F_7F7F, 32'h8080_8080, 5'd31, 1'b1);
    send_item(32'h1234_5678, 32'h9ABC_DEF0, 5'd0, 1'b1);
    send_item(32'h0101_0101, 32'h0101_0101, 5'd2, 1'b0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1);
    send_item(32'h0000_00FF, 32'h0000_007F, 5'd1, 1'b1);
    end_phase();

    // 16/16 products at the top of the range, summed until the accumulator wraps
    write_width(pidp_pkg::WP_16_16);
    repeat (3) send_item(32'h8000_8000, 32'h8000_8000, 5'd2, 1'b0);
    send_item(32'h8000_8000, 32'h8000_8000, 5'd2, 1'b1);
    send_item(32'h7FFF_8000, 32'h8000_7FFF, 5'd2, 1'b1);
    end_phase();

    // spare code adds nothing but last still emits
    write_width(WP_SPARE_HI);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16, 1'b0);
    send_item(32'h8080_8080, 32'h8080_8080, 5'd31, 1'b1);
    end_phase();

    // narrowest lanes, full and over-long counts
    write_width(pidp_pkg::WP_2_2);
    send_item(32'hAAAA_AAAA, 32'h5555_5555, 5'd16, 1'b1);
    send_item(32'hAAAA_AAAA, 32'hAAAA_AAAA, 5'd20, 1'b1);
    end_phase();

    // wide A against 2-bit B, upper B bits ignored
    write_width(pidp_pkg::WP_16_2);
    send_item(32'h8000_7FFF, 32'hFFFF_FFFA, 5'd2, 1'b1);
    end_phase();

    // random phases across every width code
    foreach (phase_codes[p]) begin
      write_width(phase_codes[p]);
      sender_burst = ($urandom_range(0, 2) == 0);
      run_vectors(22);
      end_phase();
    end

    // long output hold with back-to-back sums so the block fills and stalls its input
    write_width(pidp_pkg::WP_4_4);
    sender_burst  = 1'b1;
    long_hold_req = 300;
    repeat (40) send_item(pick_word(), pick_word(),
                          pidp_pkg::COUNT_W'($urandom_range(0, 31)), 1'b1);
    sender_burst = 1'b0;
    end_phase();

    repeat (10) @(posedge clk);
    $display("covered %0d input transactions and %0d sums over %0d width writes",
             sb.n_items, sb.n_sums, n_writes);
    $display("all ten width pairs, spare codes, clamped and zero counts, wrap, long hold");
    if (sb.errors == 0) begin
      $display("** packed_int_dot_product: PASSED **");
    end else begin
      $display("** packed_int_dot_product: FAILED **");
    end
    $finish;
  end

endmodule
